// ===== rtl/lsg_pkg.sv =====
// shared types, codes and constants for the lru slot table
package lsg_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int KEY_W          = 32;
  localparam int STAMP_W        = 32;
  localparam int GEN_W          = 4;
  localparam int SLOT_W         = 4;
  localparam int KEY_SLOT_LSB   = 28;
  localparam int KEY_GEN_LSB    = 24;
  localparam int INDEX_W        = 24;

  localparam logic [1:0] ACT_OPEN    = 2'd0;
  localparam logic [1:0] ACT_RESOLVE = 2'd1;
  localparam logic [1:0] ACT_INVAL   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_STALE     = 2'd1;
  localparam logic [1:0] ST_OPEN_FAIL = 2'd2;

  localparam logic CMP_EQ = 1'b0;
  localparam logic CMP_LT = 1'b1;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic               from_slot;
    logic [STAMP_W-1:0] last_use;
    logic [GEN_W-1:0]   gen;
  } slot_rd_t;

  typedef struct packed {
    logic               valid_en;
    logic               valid;
    logic               key_en;
    logic [KEY_W-1:0]   key;
    logic               from_slot;
    logic               lu_en;
    logic [STAMP_W-1:0] last_use;
    logic               gen_en;
    logic [GEN_W-1:0]   gen;
  } slot_wr_t;

endpackage

// ===== rtl/lsg_cmp_unit.sv =====
// shared 32-bit compare unit: equality for key search, less-than for lru scan
module lsg_cmp_unit
  import lsg_pkg::*;
(
  input  logic             op,
  input  logic [KEY_W-1:0] a,
  input  logic [KEY_W-1:0] b,
  output logic             match
);

  always_comb begin
    unique case (op)
      CMP_EQ:  match = (a == b);
      CMP_LT:  match = (a < b);
      default: match = 1'b0;
    endcase
  end

endmodule

// ===== rtl/lsg_slot_store.sv =====
// slot storage: valid bits, keys, last-use stamps and generations
module lsg_slot_store
  import lsg_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int IDX_W = $clog2(SLOT_COUNT)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear_all,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_rd_t         rd,
  input  logic [IDX_W-1:0] wr_addr,
  input  slot_wr_t         wr
);

  logic [SLOT_COUNT-1:0] valid;
  logic [KEY_W-1:0]      key_mem  [SLOT_COUNT];
  logic                  fs_mem   [SLOT_COUNT];
  logic [STAMP_W-1:0]    lu_mem   [SLOT_COUNT];
  logic [GEN_W-1:0]      gen_mem  [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (clear_all) begin
      valid <= '0;
    end else if (wr.valid_en) begin
      valid[wr_addr] <= wr.valid;
    end
  end

  // generations and stamps have a defined reset, keys do not
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        lu_mem[i]  <= '0;
        gen_mem[i] <= '0;
      end
    end else begin
      if (wr.lu_en) begin
        lu_mem[wr_addr] <= wr.last_use;
      end
      if (wr.gen_en) begin
        gen_mem[wr_addr] <= wr.gen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.key_en) begin
      key_mem[wr_addr] <= wr.key;
      fs_mem[wr_addr]  <= wr.from_slot;
    end
  end

  assign rd.valid     = valid[rd_addr];
  assign rd.key       = key_mem[rd_addr];
  assign rd.from_slot = fs_mem[rd_addr];
  assign rd.last_use  = lu_mem[rd_addr];
  assign rd.gen       = gen_mem[rd_addr];

endmodule

// ===== rtl/lru_slot_table_with_generations.sv =====
// top level: lru slot table with generation tags, sequencer over one slot per cycle
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------------
//  request  | start, busy       | action, entry_key, entry_from_slot, open_ok
//  result   | done (one cycle)  | status, was_hit, slot, generation,
//           |                   | parent_is_root, parent_slot, child_index
//
//  a request transfers when start is high and busy is low; busy stays high until
//  the cycle after done. invalidate and unused actions go straight to done, resolve checks
//  the parent first. open walks the slots one per cycle through one read port and one
//  comparator: a hit ends the search, a miss goes on to the parent, victim and commit steps.
//  synchronous reset clears valid bits, stamps, generations and the use counter.
//  the result is valid in the done cycle and holds until the next request is accepted; the receiver cannot stall.
module lru_slot_table_with_generations
  import lsg_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         action,
  input  logic [KEY_W-1:0]   entry_key,
  input  logic               entry_from_slot,
  input  logic               open_ok,
  output logic               done,
  output logic [1:0]         status,
  output logic               was_hit,
  output logic [SLOT_W-1:0]  slot,
  output logic [GEN_W-1:0]   generation,
  output logic               parent_is_root,
  output logic [SLOT_W-1:0]  parent_slot,
  output logic [KEY_W-1:0]   child_index
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HIT    = 3'd1;
  localparam logic [2:0] S_PARENT = 3'd2;
  localparam logic [2:0] S_VICTIM = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]         state, state_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [IDX_W-1:0]   victim, victim_next;
  logic [STAMP_W-1:0] best_lu, best_lu_next;
  logic [STAMP_W-1:0] use_counter, use_counter_next;
  logic [1:0]         act_q, act_q_next;
  logic [KEY_W-1:0]   key_q, key_q_next;
  logic               fs_q, fs_q_next;
  logic               ok_q, ok_q_next;

  logic [1:0]         status_next;
  logic               was_hit_next;
  logic [SLOT_W-1:0]  slot_next;
  logic [GEN_W-1:0]   generation_next;
  logic               parent_is_root_next;
  logic [SLOT_W-1:0]  parent_slot_next;
  logic [KEY_W-1:0]   child_index_next;

  logic               clear_all;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  slot_rd_t           rd;
  slot_wr_t           wr;
  logic               cmp_op;
  logic [KEY_W-1:0]   cmp_a;
  logic [KEY_W-1:0]   cmp_b;
  logic               cmp_match;

  logic [STAMP_W-1:0] stamp_val;
  logic [SLOT_W-1:0]  par_slot;
  logic [GEN_W-1:0]   par_gen;
  logic               par_in_range;
  logic [GEN_W-1:0]   gen_bumped;

  lsg_slot_store #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .clear_all(clear_all),
    .rd_addr  (rd_addr),
    .rd       (rd),
    .wr_addr  (wr_addr),
    .wr       (wr)
  );

  lsg_cmp_unit u_cmp (
    .op   (cmp_op),
    .a    (cmp_a),
    .b    (cmp_b),
    .match(cmp_match)
  );

  assign stamp_val    = use_counter + STAMP_W'(1);
  assign par_slot     = key_q[KEY_SLOT_LSB +: SLOT_W];
  assign par_gen      = key_q[KEY_GEN_LSB +: GEN_W];
  assign par_in_range = (32'(par_slot) < SLOT_COUNT);
  assign gen_bumped   = rd.gen + GEN_W'(1);

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    state_next          = state;
    idx_next            = idx;
    victim_next         = victim;
    best_lu_next        = best_lu;
    use_counter_next    = use_counter;
    act_q_next          = act_q;
    key_q_next          = key_q;
    fs_q_next           = fs_q;
    ok_q_next           = ok_q;
    status_next         = status;
    was_hit_next        = was_hit;
    slot_next           = slot;
    generation_next     = generation;
    parent_is_root_next = parent_is_root;
    parent_slot_next    = parent_slot;
    child_index_next    = child_index;
    clear_all           = 1'b0;
    rd_addr             = idx;
    wr_addr             = idx;
    wr                  = '0;
    cmp_op              = CMP_EQ;
    cmp_a               = rd.key;
    cmp_b               = key_q;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          act_q_next          = action;
          key_q_next          = entry_key;
          fs_q_next           = entry_from_slot;
          ok_q_next           = open_ok;
          status_next         = ST_OK;
          was_hit_next        = 1'b0;
          slot_next           = '0;
          generation_next     = '0;
          parent_is_root_next = 1'b0;
          parent_slot_next    = '0;
          child_index_next    = '0;
          idx_next            = '0;
          if (action == ACT_OPEN || action == ACT_RESOLVE) begin
            parent_is_root_next = !entry_from_slot;
            if (entry_from_slot) begin
              parent_slot_next = entry_key[KEY_SLOT_LSB +: SLOT_W];
              child_index_next = {{(KEY_W-INDEX_W){1'b0}}, entry_key[INDEX_W-1:0]};
            end else begin
              child_index_next = entry_key;
            end
          end
          unique case (action)
            ACT_OPEN:    state_next = S_HIT;
            ACT_RESOLVE: state_next = S_PARENT;
            ACT_INVAL: begin
              clear_all  = 1'b1;
              state_next = S_DONE;
            end
            default:     state_next = S_DONE;
          endcase
        end
      end

      // search for the key, one slot per cycle
      S_HIT: begin
        if (rd.valid && cmp_match && (rd.from_slot == fs_q)) begin
          wr.lu_en         = 1'b1;
          wr.last_use      = stamp_val;
          use_counter_next = stamp_val;
          was_hit_next     = 1'b1;
          slot_next        = SLOT_W'(idx);
          generation_next  = rd.gen;
          state_next       = S_DONE;
        end else if (idx == IDX_LAST) begin
          state_next = S_PARENT;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end

      // parent must be root or a live slot with matching generation
      S_PARENT: begin
        rd_addr = par_slot[IDX_W-1:0];
        wr_addr = par_slot[IDX_W-1:0];
        idx_next = '0;
        if (!fs_q || (par_in_range && rd.valid && (rd.gen == par_gen))) begin
          if (fs_q) begin
            wr.lu_en         = 1'b1;
            wr.last_use      = stamp_val;
            use_counter_next = stamp_val;
          end
          state_next = (act_q == ACT_OPEN) ? S_VICTIM : S_DONE;
        end else begin
          status_next = ST_STALE;
          state_next  = S_DONE;
        end
      end

      // first free slot wins, else smallest stamp with ties to lowest index
      S_VICTIM: begin
        cmp_op = CMP_LT;
        cmp_a  = rd.last_use;
        cmp_b  = best_lu;
        if (!rd.valid) begin
          victim_next = idx;
          state_next  = S_COMMIT;
        end else begin
          if (idx == '0 || cmp_match) begin
            victim_next  = idx;
            best_lu_next = rd.last_use;
          end
          if (idx == IDX_LAST) begin
            state_next = S_COMMIT;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end

      S_COMMIT: begin
        rd_addr      = victim;
        wr_addr      = victim;
        wr.gen_en    = 1'b1;
        wr.gen       = gen_bumped;
        wr.valid_en  = 1'b1;
        wr.valid     = ok_q;
        if (ok_q) begin
          wr.key_en        = 1'b1;
          wr.key           = key_q;
          wr.from_slot     = fs_q;
          wr.lu_en         = 1'b1;
          wr.last_use      = stamp_val;
          use_counter_next = stamp_val;
          slot_next        = SLOT_W'(victim);
          generation_next  = gen_bumped;
        end else begin
          status_next = ST_OPEN_FAIL;
        end
        state_next = S_DONE;
      end

      S_DONE: begin
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      use_counter <= '0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      use_counter <= use_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    victim         <= victim_next;
    best_lu        <= best_lu_next;
    act_q          <= act_q_next;
    key_q          <= key_q_next;
    fs_q           <= fs_q_next;
    ok_q           <= ok_q_next;
    status         <= status_next;
    was_hit        <= was_hit_next;
    slot           <= slot_next;
    generation     <= generation_next;
    parent_is_root <= parent_is_root_next;
    parent_slot    <= parent_slot_next;
    child_index    <= child_index_next;
  end

endmodule
